// ===== rtl/aspect_fit_palette_scaler_defines.svh =====
// Assertion helpers for the scaler.
`ifndef ASPECT_FIT_PALETTE_SCALER_DEFINES_SVH
`define ASPECT_FIT_PALETTE_SCALER_DEFINES_SVH

// same-cycle implication
`define AFPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("afps: implication check failed");

// next-cycle implication
`define AFPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("afps: next-cycle check failed");

`endif

// ===== rtl/afps_pkg.sv =====
package afps_pkg;

	localparam int DEF_SCREEN_WIDTH  = 396;
	localparam int DEF_SCREEN_HEIGHT = 224;
	localparam int DEF_FRAME_DEPTH   = 65536;

	// source dimensions and cropped quotients
	localparam int DIM_W = 10;

	// register indexes
	localparam logic [1:0] REG_SRC_WIDTH   = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_FRAME_VALID = 2'd2;

	// transaction kinds
	localparam logic [1:0] KIND_PAL_WR = 2'd0;
	localparam logic [1:0] KIND_PIX_WR = 2'd1;
	localparam logic [1:0] KIND_PIX_RD = 2'd2;

	typedef enum logic [2:0] {
		GEO_IDLE,
		GEO_VDIV,
		GEO_VCHK,
		GEO_WDIV,
		GEO_WCHK,
		GEO_FIN
	} geo_state_t;

	typedef struct packed {
		logic        vld;
		logic [1:0]  kind;
		logic [15:0] waddr;
		logic [15:0] wdata;
		logic        in_pic;
	} side_t;

endpackage

// ===== rtl/aspect_fit_palette_scaler.sv =====
// Channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid/in_ready   | kind, write_addr, write_data, screen_x/_y
// output   | out_valid/out_ready | color, in_picture
// config   | cfg_we              | cfg_index, cfg_data
//
// One transaction per clock, except while a register write, the geometry
// rerun or a held result stalls input. A pixel request passes the input
// register, offset/multiply, ten divider stages (one quotient bit each),
// address multiply-add, frame RAM read, palette RAM read and the output
// register, which raises out_valid. A register write reruns the fit
// geometry on a bit-serial divider while input stalls.
// Reset clears control only; the RAMs need no clearing pass. A held result
// stalls the pipe only once the next result reaches the palette stage.
`include "aspect_fit_palette_scaler_defines.svh"

module aspect_fit_palette_scaler #(
	parameter int SCREEN_WIDTH  = afps_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = afps_pkg::DEF_SCREEN_HEIGHT,
	parameter int FRAME_DEPTH   = afps_pkg::DEF_FRAME_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] write_addr,
	input  logic [15:0] write_data,
	input  logic [8:0]  screen_x,
	input  logic [7:0]  screen_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] color,
	output logic        in_picture,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import afps_pkg::*;

	localparam int SWB = $clog2(SCREEN_WIDTH + 1);
	localparam int SHB = $clog2(SCREEN_HEIGHT + 1);
	localparam int XC  = ((SWB > 9) ? SWB : 9) + 1;
	localparam int YC  = ((SHB > 8) ? SHB : 8) + 1;
	localparam int NXW = SWB + DIM_W;
	localparam int NYW = SHB + DIM_W;
	localparam int AW  = 2 * DIM_W;
	localparam int FAW = $clog2(FRAME_DEPTH);
	localparam int ND  = DIM_W;

	// ---------------- configuration registers
	logic [DIM_W-1:0] src_w_q, src_h_q;
	logic             fv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			fv_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:   src_w_q <= cfg_data;
				REG_SRC_HEIGHT:  src_h_q <= cfg_data;
				REG_FRAME_VALID: fv_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- fit geometry
	logic           geo_busy, geo_empty;
	logic [SWB-1:0] geo_x0, geo_wd;
	logic [SHB-1:0] geo_y0, geo_vh;

	afps_geom #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.SWB          (SWB),
		.SHB          (SHB)
	) u_geom (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_we),
		.src_w (src_w_q),
		.src_h (src_h_q),
		.busy  (geo_busy),
		.empty (geo_empty),
		.x0    (geo_x0),
		.y0    (geo_y0),
		.wd    (geo_wd),
		.vh    (geo_vh)
	);

	// ---------------- flow control
	// The whole pipe moves together; it holds only when a result sits in
	// the palette stage and the output register is still occupied.
	side_t       side_s5;
	logic [15:0] color_q;
	logic        in_pic_q, out_valid_q;
	logic        adv;
	logic        accept;

	assign adv      = !(side_s5.vld && side_s5.kind == KIND_PIX_RD && out_valid_q && !out_ready);
	assign in_ready = adv && !geo_busy && !cfg_we;
	assign accept   = in_valid && in_ready;

	// ---------------- s1: input register
	logic        vld_s1;
	logic [1:0]  kind_s1;
	logic [15:0] waddr_s1, wdata_s1;
	logic [8:0]  sx_s1;
	logic [7:0]  sy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= kind;
			waddr_s1 <= write_addr;
			wdata_s1 <= write_data;
			sx_s1    <= screen_x;
			sy_s1    <= screen_y;
		end
	end

	// ---------------- s2: window test and dividends
	logic [XC-1:0]  sx_e, x0_e, x1_e, dx_e;
	logic [YC-1:0]  sy_e, y0_e, y1_e, dy_e;
	logic           in_win;
	logic [NXW-1:0] num_x_s2;
	logic [NYW-1:0] num_y_s2;
	side_t          side_s2;

	assign sx_e   = XC'(sx_s1);
	assign x0_e   = XC'(geo_x0);
	assign x1_e   = XC'(geo_x0) + XC'(geo_wd);
	assign dx_e   = sx_e - x0_e;
	assign sy_e   = YC'(sy_s1);
	assign y0_e   = YC'(geo_y0);
	assign y1_e   = YC'(geo_y0) + YC'(geo_vh);
	assign dy_e   = sy_e - y0_e;
	assign in_win = fv_q && !geo_empty && sx_e >= x0_e && sx_e < x1_e
		&& sy_e >= y0_e && sy_e < y1_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2 <= '{vld: vld_s1, kind: kind_s1, waddr: waddr_s1,
				wdata: wdata_s1, in_pic: in_win};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s2 <= NXW'(dx_e[SWB-1:0]) * NXW'(src_w_q);
			num_y_s2 <= NYW'(dy_e[SHB-1:0]) * NYW'(src_h_q);
		end
	end

	// ---------------- divider stages: column and row
	logic [DIM_W-1:0] col_q, row_q;
	side_t            side_dl [ND];

	afps_divpipe #(.DVW(SWB), .QW(DIM_W)) u_div_x (
		.clk(clk), .en(adv), .num(num_x_s2), .div(geo_wd), .quo(col_q)
	);

	afps_divpipe #(.DVW(SHB), .QW(DIM_W)) u_div_y (
		.clk(clk), .en(adv), .num(num_y_s2), .div(geo_vh), .quo(row_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ND; k++) side_dl[k] <= '0;
		end else if (adv) begin
			side_dl[0] <= side_s2;
			for (int k = 1; k < ND; k++) side_dl[k] <= side_dl[k-1];
		end
	end

	// ---------------- s3: linear source address
	logic [AW-1:0] addr_s3;
	side_t         side_s3;
	logic          oob_s3;
	logic          fwr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= side_dl[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s3 <= AW'(row_q) * AW'(src_w_q) + AW'(col_q);
		end
	end

	assign oob_s3 = (32'(addr_s3) >= 32'(FRAME_DEPTH));
	assign fwr_s3 = side_s3.vld && side_s3.kind == KIND_PIX_WR
		&& 32'(side_s3.waddr) < 32'(FRAME_DEPTH);

	// ---------------- s4: frame RAM (writes and reads in program order)
	logic [7:0] frame_mem [FRAME_DEPTH];
	logic [7:0] fidx_s4;
	side_t      side_s4;
	logic       ok_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fwr_s3) frame_mem[FAW'(side_s3.waddr)] <= side_s3.wdata[7:0];
			fidx_s4 <= frame_mem[FAW'(addr_s3)];
			ok_s4   <= side_s3.in_pic && !oob_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (adv) begin
			side_s4 <= side_s3;
		end
	end

	// ---------------- s5: palette RAM
	logic [15:0] pal_mem [256];
	logic [15:0] pal_s5;
	logic        ok_s5;
	logic        pwr_s4;

	assign pwr_s4 = side_s4.vld && side_s4.kind == KIND_PAL_WR && side_s4.waddr[15:8] == 8'd0;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pwr_s4) pal_mem[side_s4.waddr[7:0]] <= side_s4.wdata;
			pal_s5 <= pal_mem[fidx_s4];
			ok_s5  <= ok_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (adv) begin
			side_s5 <= side_s4;
		end
	end

	// ---------------- output register
	logic load_out;

	assign load_out = side_s5.vld && side_s5.kind == KIND_PIX_RD && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			color_q  <= ok_s5 ? pal_s5 : 16'd0;
			in_pic_q <= side_s5.in_pic;
		end
	end

	assign out_valid  = out_valid_q;
	assign color      = color_q;
	assign in_picture = in_pic_q;

	// ---------------- checks
	`AFPS_ASSERT_IMP(a_geo_blocks_input, clk, arst_n, geo_busy, !in_ready)
	`AFPS_ASSERT_IMP(a_stall_blocks_input, clk, arst_n,
		side_s5.vld && side_s5.kind == KIND_PIX_RD && out_valid_q && !out_ready, !in_ready)
	`AFPS_ASSERT_IMP(a_outside_is_black, clk, arst_n, out_valid_q && !in_pic_q, color_q == 16'd0)

endmodule

// ===== rtl/afps_divpipe.sv =====
// One quotient bit per stage; dividend high part must be below the divisor.
module afps_divpipe #(
	parameter int DVW = 9,
	parameter int QW  = 10
) (
	input  logic               clk,
	input  logic               en,
	input  logic [DVW+QW-1:0]  num,
	input  logic [DVW-1:0]     div,
	output logic [QW-1:0]      quo
);

	logic [DVW-1:0] rem_q  [QW];
	logic [QW-1:0]  low_q  [QW];
	logic [DVW-1:0] rem_in [QW];
	logic [QW-1:0]  low_in [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [DVW:0] t;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in[k] = num[DVW+QW-1:QW];
			assign low_in[k] = num[QW-1:0];
		end else begin : g_next
			assign rem_in[k] = rem_q[k-1];
			assign low_in[k] = low_q[k-1];
		end

		assign t  = {rem_in[k], low_in[k][QW-1]};
		assign ge = (t >= {1'b0, div});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? DVW'(t - {1'b0, div}) : t[DVW-1:0];
				low_q[k] <= {low_in[k][QW-2:0], ge};
			end
		end
	end

	assign quo = low_q[QW-1];

endmodule

// ===== rtl/afps_geom.sv =====
// Fit geometry: shared bit-serial divider, rerun after every register write.
module afps_geom #(
	parameter int SCREEN_WIDTH  = afps_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = afps_pkg::DEF_SCREEN_HEIGHT,
	parameter int SWB = $clog2(SCREEN_WIDTH + 1),
	parameter int SHB = $clog2(SCREEN_HEIGHT + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [afps_pkg::DIM_W-1:0] src_w,
	input  logic [afps_pkg::DIM_W-1:0] src_h,
	output logic                       busy,
	output logic                       empty,
	output logic [SWB-1:0]             x0,
	output logic [SHB-1:0]             y0,
	output logic [SWB-1:0]             wd,
	output logic [SHB-1:0]             vh
);
	import afps_pkg::*;

	localparam int MXB = (SWB > SHB) ? SWB : SHB;
	localparam int DW  = DIM_W + MXB;
	localparam int CW  = $clog2(DW);

	geo_state_t       state_q, state_d;
	logic             dirty_q;
	logic [DW-1:0]    num_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic [DIM_W:0]   t;
	logic             ge;
	logic             cnt_end;

	assign t       = {rem_q, num_q[DW-1]};
	assign ge      = (t >= {1'b0, dsr_q});
	assign cnt_end = (cnt_q == CW'(DW - 1));
	assign busy    = dirty_q || (state_q != GEO_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEO_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			GEO_IDLE: begin
				if (dirty_q && src_w != '0 && src_h != '0) state_d = GEO_VDIV;
			end
			GEO_VDIV: if (cnt_end) state_d = GEO_VCHK;
			GEO_VCHK: begin
				if (num_q > DW'(SCREEN_HEIGHT)) state_d = GEO_WDIV;
				else state_d = GEO_FIN;
			end
			GEO_WDIV: if (cnt_end) state_d = GEO_WCHK;
			GEO_WCHK: state_d = GEO_FIN;
			GEO_FIN:  state_d = GEO_IDLE;
			default:  state_d = GEO_IDLE;
		endcase
	end

	// dirty starts set so reset values get a geometry too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b1;
			empty   <= 1'b1;
		end else begin
			if (start) begin
				dirty_q <= 1'b1;
			end else if (state_q == GEO_IDLE) begin
				dirty_q <= 1'b0;
			end
			if (state_q == GEO_IDLE && dirty_q && (src_w == '0 || src_h == '0)) begin
				empty <= 1'b1;
			end else if (state_q == GEO_VCHK && num_q <= DW'(SCREEN_HEIGHT)) begin
				empty <= (num_q == '0);
			end else if (state_q == GEO_WCHK) begin
				empty <= (num_q == '0) || (num_q > DW'(SCREEN_WIDTH));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			GEO_IDLE: begin
				num_q <= DW'(src_h) * DW'(SCREEN_WIDTH);
				dsr_q <= src_w;
				rem_q <= '0;
				cnt_q <= '0;
			end
			GEO_VDIV, GEO_WDIV: begin
				rem_q <= ge ? DIM_W'(t - {1'b0, dsr_q}) : t[DIM_W-1:0];
				num_q <= {num_q[DW-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
			end
			GEO_VCHK: begin
				if (num_q > DW'(SCREEN_HEIGHT)) begin
					vh    <= SHB'(SCREEN_HEIGHT);
					num_q <= DW'(src_w) * DW'(SCREEN_HEIGHT);
					dsr_q <= src_h;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					vh <= num_q[SHB-1:0];
					wd <= SWB'(SCREEN_WIDTH);
				end
			end
			GEO_WCHK: wd <= num_q[SWB-1:0];
			GEO_FIN: begin
				x0 <= (SWB'(SCREEN_WIDTH) - wd) >> 1;
				y0 <= (SHB'(SCREEN_HEIGHT) - vh) >> 1;
			end
			default: ;
		endcase
	end

endmodule
